@@ sv/acg_pkg.sv @@
// shared constants, codes and command/status types for the greedy class assigner
// no dependencies
package acg_pkg;

  localparam int MAX_CELLS   = 4096;
  localparam int MAX_CLASSES = 8;
  localparam int CELL_W      = $clog2(MAX_CELLS);
  localparam int CNT_W       = $clog2(MAX_CELLS + 1);
  localparam int CLASS_W     = $clog2(MAX_CLASSES);
  localparam int CCNT_W      = $clog2(MAX_CLASSES + 1);
  localparam int ID_W        = 31;
  localparam int CHANCE_W    = 32;

  localparam logic [1:0] OP_SET_CLASS   = 2'd0;
  localparam logic [1:0] OP_LOAD_CHANCE = 2'd1;
  localparam logic [1:0] OP_RUN         = 2'd2;
  localparam logic [1:0] OP_READ        = 2'd3;

  localparam logic [3:0] CMD_NOP       = 4'd0;
  localparam logic [3:0] CMD_SET       = 4'd1;
  localparam logic [3:0] CMD_LOAD      = 4'd2;
  localparam logic [3:0] CMD_RUN_START = 4'd3;
  localparam logic [3:0] CMD_READ      = 4'd4;
  localparam logic [3:0] CMD_OUT_LOAD  = 4'd5;
  localparam logic [3:0] CMD_PREP_RD   = 4'd6;
  localparam logic [3:0] CMD_PREP_ACC  = 4'd7;
  localparam logic [3:0] CMD_PREP_WR   = 4'd8;
  localparam logic [3:0] CMD_SEL_INIT  = 4'd9;
  localparam logic [3:0] CMD_LRD       = 4'd10;
  localparam logic [3:0] CMD_CRD       = 4'd11;
  localparam logic [3:0] CMD_CMP       = 4'd12;
  localparam logic [3:0] CMD_ASSIGN    = 4'd13;
  localparam logic [3:0] CMD_SWAP1     = 4'd14;
  localparam logic [3:0] CMD_SWAP2     = 4'd15;

  typedef struct packed {
    logic [3:0] code;
  } acg_cmd_t;

  typedef struct packed {
    logic out_free;
    logic k_last;
    logic c_last;
    logic p_last;
    logic k_max;
    logic active_k;
    logic sel_done;
  } acg_stat_t;

endpackage

@@ sv/acg_if.sv @@
// valid/ready channel interfaces for input and result words
// depends on acg_pkg
interface acg_in_if;
  import acg_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          operation;
  logic [CLASS_W-1:0]  class_index;
  logic [CELL_W-1:0]   cell_index;
  logic [ID_W-1:0]     class_id;
  logic [12:0]         area_limit;
  logic signed [31:0]  chance;
  logic                chance_missing;
  logic [12:0]         cell_count;
  logic [3:0]          class_count;
  modport source (output valid, operation, class_index, cell_index, class_id, area_limit,
                  chance, chance_missing, cell_count, class_count, input ready);
  modport sink (input valid, operation, class_index, cell_index, class_id, area_limit,
                chance, chance_missing, cell_count, class_count, output ready);
endinterface

interface acg_out_if;
  import acg_pkg::*;
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] result_cell;
  logic [ID_W-1:0]   result_class_id;
  logic              result_missing;
  modport source (output valid, result_cell, result_class_id, result_missing, input ready);
  modport sink (input valid, result_cell, result_class_id, result_missing, output ready);
endinterface

@@ sv/acg_ctrl.sv @@
// sequencer for load, read and greedy assignment run
// depends on acg_pkg
module acg_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_op,
  input  logic [12:0]        in_cell_count,
  output logic               in_ready,
  input  acg_pkg::acg_stat_t stat,
  output acg_pkg::acg_cmd_t  cmd
);
  import acg_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_RDATA    = 4'd1;
  localparam logic [3:0] S_PREP_RD  = 4'd2;
  localparam logic [3:0] S_PREP_ACC = 4'd3;
  localparam logic [3:0] S_PREP_WR  = 4'd4;
  localparam logic [3:0] S_SEL_INIT = 4'd5;
  localparam logic [3:0] S_LRD      = 4'd6;
  localparam logic [3:0] S_CRD      = 4'd7;
  localparam logic [3:0] S_CMP      = 4'd8;
  localparam logic [3:0] S_ASSIGN   = 4'd9;
  localparam logic [3:0] S_SWAP1    = 4'd10;
  localparam logic [3:0] S_SWAP2    = 4'd11;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.code  = CMD_NOP;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_op)
            OP_SET_CLASS:   cmd.code = CMD_SET;
            OP_LOAD_CHANCE: cmd.code = CMD_LOAD;
            OP_RUN: begin
              cmd.code = CMD_RUN_START;
              if (in_cell_count != '0) state_nxt = S_PREP_RD;
            end
            default: begin
              cmd.code  = CMD_READ;
              state_nxt = S_RDATA;
            end
          endcase
        end
      end
      S_RDATA: begin
        if (stat.out_free) begin
          cmd.code  = CMD_OUT_LOAD;
          state_nxt = S_IDLE;
        end
      end
      S_PREP_RD: begin
        cmd.code  = CMD_PREP_RD;
        state_nxt = S_PREP_ACC;
      end
      S_PREP_ACC: begin
        cmd.code  = CMD_PREP_ACC;
        state_nxt = stat.k_last ? S_PREP_WR : S_PREP_RD;
      end
      S_PREP_WR: begin
        cmd.code  = CMD_PREP_WR;
        state_nxt = stat.c_last ? S_SEL_INIT : S_PREP_RD;
      end
      S_SEL_INIT: begin
        cmd.code  = CMD_SEL_INIT;
        state_nxt = stat.sel_done ? S_IDLE : S_LRD;
      end
      S_LRD: begin
        cmd.code = CMD_LRD;
        if (!stat.active_k) state_nxt = stat.k_max ? S_ASSIGN : S_LRD;
        else                state_nxt = S_CRD;
      end
      S_CRD: begin
        cmd.code  = CMD_CRD;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.code  = CMD_CMP;
        state_nxt = (stat.p_last && stat.k_max) ? S_ASSIGN : S_LRD;
      end
      S_ASSIGN: begin
        cmd.code  = CMD_ASSIGN;
        state_nxt = S_SWAP1;
      end
      S_SWAP1: begin
        cmd.code  = CMD_SWAP1;
        state_nxt = S_SWAP2;
      end
      S_SWAP2: begin
        cmd.code  = CMD_SWAP2;
        state_nxt = S_SEL_INIT;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

@@ sv/acg_dp.sv @@
// datapath: chance, result and work-list memories, class registers, best-pair search
// depends on acg_pkg
module acg_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  acg_pkg::acg_cmd_t          cmd,
  output acg_pkg::acg_stat_t         stat,
  input  logic [acg_pkg::CLASS_W-1:0] in_class_index,
  input  logic [acg_pkg::CELL_W-1:0] in_cell_index,
  input  logic [acg_pkg::ID_W-1:0]   in_class_id,
  input  logic [12:0]                in_area_limit,
  input  logic [31:0]                in_chance,
  input  logic                       in_chance_missing,
  input  logic [12:0]                in_cell_count,
  input  logic [3:0]                 in_class_count,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [acg_pkg::CELL_W-1:0] out_cell,
  output logic [acg_pkg::ID_W-1:0]   out_class_id,
  output logic                       out_missing
);
  import acg_pkg::*;

  localparam int CADDR_W = CLASS_W + CELL_W;

  logic [CHANCE_W:0]  chance_mem [MAX_CLASSES*MAX_CELLS];
  logic [ID_W:0]      res_mem    [MAX_CELLS];
  logic [CELL_W-1:0]  list_mem   [MAX_CELLS];

  logic [CHANCE_W:0]  cq;
  logic [ID_W:0]      rq;
  logic [CELL_W-1:0]  lq;

  logic [ID_W-1:0]    ids_r      [MAX_CLASSES];
  logic [CNT_W-1:0]   limits_r   [MAX_CLASSES];
  logic [CNT_W-1:0]   assigned_r [MAX_CLASSES];
  logic [MAX_CLASSES-1:0] active_r;

  logic [CNT_W-1:0]   n_r, c_r, p_r, len_r, start_r;
  logic [CCNT_W-1:0]  m_r;
  logic [CLASS_W-1:0] k_r, best_class_r;
  logic               miss_r, found_r;
  logic [CHANCE_W-1:0] best_key_r;
  logic [CNT_W-1:0]   best_pos_r;
  logic [CELL_W-1:0]  best_cell_r, cur_cell_r, old_r, rd_cell_r;
  logic               out_valid_r;
  logic [ID_W-1:0]    out_id_r;
  logic               out_miss_r;

  logic               noact, k_in;
  logic [CHANCE_W-1:0] key;
  logic [CADDR_W-1:0] c_raddr;
  logic [CELL_W-1:0]  l_raddr, l_waddr, r_waddr, r_raddr;
  logic [CELL_W-1:0]  l_wdata;
  logic [ID_W:0]      r_wdata;
  logic               l_we, r_we;
  logic [CNT_W-1:0]   asg_inc;

  assign noact = ~(|active_r);
  assign k_in  = ({1'b0, k_r} < m_r);
  assign key   = cq[CHANCE_W-1:0] ^ {1'b1, {(CHANCE_W-1){1'b0}}};
  assign asg_inc = assigned_r[best_class_r] + 1'b1;

  assign stat.out_free = ~out_valid_r | out_ready;
  assign stat.k_last   = (({1'b0, k_r} + 1'b1) >= m_r);
  assign stat.c_last   = ((c_r + 1'b1) >= n_r);
  assign stat.p_last   = ((p_r + 1'b1) >= len_r);
  assign stat.k_max    = (k_r == CLASS_W'(MAX_CLASSES - 1));
  assign stat.active_k = active_r[k_r];
  assign stat.sel_done = noact | (start_r >= len_r);

  // memory address and write selection
  always_comb begin
    c_raddr = (cmd.code == CMD_CRD) ? {k_r, lq} : {k_r, c_r[CELL_W-1:0]};
    l_raddr = (cmd.code == CMD_ASSIGN) ? start_r[CELL_W-1:0] : p_r[CELL_W-1:0];
    r_raddr = in_cell_index;
    l_we    = 1'b0;
    l_waddr = len_r[CELL_W-1:0];
    l_wdata = c_r[CELL_W-1:0];
    r_we    = 1'b0;
    r_waddr = c_r[CELL_W-1:0];
    r_wdata = {miss_r, {ID_W{1'b0}}};
    case (cmd.code)
      CMD_PREP_WR: begin
        r_we = 1'b1;
        l_we = ~miss_r & ~noact;
      end
      CMD_ASSIGN: begin
        r_we    = 1'b1;
        r_waddr = best_cell_r;
        r_wdata = {1'b0, ids_r[best_class_r]};
      end
      CMD_SWAP1: begin
        l_we    = 1'b1;
        l_waddr = start_r[CELL_W-1:0];
        l_wdata = best_cell_r;
      end
      CMD_SWAP2: begin
        l_we    = 1'b1;
        l_waddr = best_pos_r[CELL_W-1:0];
        l_wdata = old_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.code == CMD_LOAD)
      chance_mem[{in_class_index, in_cell_index}] <= {in_chance_missing, in_chance};
    cq <= chance_mem[c_raddr];
  end

  // read data held until the output register takes it
  always_ff @(posedge clk) begin
    if (r_we) res_mem[r_waddr] <= r_wdata;
    if (cmd.code == CMD_READ) rq <= res_mem[r_raddr];
  end

  always_ff @(posedge clk) begin
    if (l_we) list_mem[l_waddr] <= l_wdata;
    lq <= list_mem[l_raddr];
  end

  // class registers
  always_ff @(posedge clk) begin
    if (cmd.code == CMD_SET) begin
      ids_r[in_class_index]    <= in_class_id;
      limits_r[in_class_index] <= (in_area_limit > 13'(MAX_CELLS)) ?
                                  CNT_W'(MAX_CELLS) : CNT_W'(in_area_limit);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      for (int i = 0; i < MAX_CLASSES; i++) assigned_r[i] <= '0;
    end else if (cmd.code == CMD_RUN_START) begin
      for (int i = 0; i < MAX_CLASSES; i++) begin
        assigned_r[i] <= '0;
        active_r[i]   <= (CCNT_W'(i) < ((in_class_count > 4'(MAX_CLASSES)) ?
                          CCNT_W'(MAX_CLASSES) : CCNT_W'(in_class_count)))
                         && (limits_r[i] != '0);
      end
    end else if (cmd.code == CMD_ASSIGN) begin
      assigned_r[best_class_r] <= asg_inc;
      if (asg_inc >= limits_r[best_class_r]) active_r[best_class_r] <= 1'b0;
    end
  end

  // run counters and search registers
  always_ff @(posedge clk) begin
    case (cmd.code)
      CMD_RUN_START: begin
        n_r     <= (in_cell_count > 13'(MAX_CELLS)) ? CNT_W'(MAX_CELLS) : CNT_W'(in_cell_count);
        m_r     <= (in_class_count > 4'(MAX_CLASSES)) ?
                   CCNT_W'(MAX_CLASSES) : CCNT_W'(in_class_count);
        k_r     <= '0;
        c_r     <= '0;
        len_r   <= '0;
        start_r <= '0;
        miss_r  <= 1'b0;
      end
      CMD_PREP_ACC: begin
        if (cq[CHANCE_W] && k_in && (noact || active_r[k_r])) miss_r <= 1'b1;
        if (!stat.k_last) k_r <= k_r + 1'b1;
      end
      CMD_PREP_WR: begin
        if (l_we) len_r <= len_r + 1'b1;
        miss_r <= 1'b0;
        k_r    <= '0;
        c_r    <= c_r + 1'b1;
      end
      CMD_SEL_INIT: begin
        k_r     <= '0;
        p_r     <= start_r;
        found_r <= 1'b0;
      end
      CMD_LRD: begin
        if (!active_r[k_r] && !stat.k_max) begin
          k_r <= k_r + 1'b1;
          p_r <= start_r;
        end
      end
      CMD_CRD: cur_cell_r <= lq;
      CMD_CMP: begin
        if (!found_r || key > best_key_r) begin
          found_r      <= 1'b1;
          best_key_r   <= key;
          best_class_r <= k_r;
          best_pos_r   <= p_r;
          best_cell_r  <= cur_cell_r;
        end
        if (!stat.p_last) p_r <= p_r + 1'b1;
        else if (!stat.k_max) begin
          k_r <= k_r + 1'b1;
          p_r <= start_r;
        end
      end
      CMD_SWAP1: old_r   <= lq;
      CMD_SWAP2: start_r <= start_r + 1'b1;
      CMD_READ:  rd_cell_r <= in_cell_index;
      default: ;
    endcase
  end

  // result output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.code == CMD_OUT_LOAD) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.code == CMD_OUT_LOAD) begin
      out_id_r   <= rq[ID_W] ? '0 : rq[ID_W-1:0];
      out_miss_r <= rq[ID_W];
    end
  end

  logic [CELL_W-1:0] out_cell_r;
  always_ff @(posedge clk) begin
    if (cmd.code == CMD_OUT_LOAD) out_cell_r <= rd_cell_r;
  end

  assign out_valid    = out_valid_r;
  assign out_cell     = out_cell_r;
  assign out_class_id = out_id_r;
  assign out_missing  = out_miss_r;

endmodule

@@ sv/area_limited_greedy_class_assign.sv @@
// top level of the area-limited greedy class assigner
// depends on acg_pkg, acg_if, acg_ctrl, acg_dp
//
// Set-class and load-chance words are taken one per cycle while the sequencer
// is idle. A read word goes through the result memory read, then the output
// register load, and the result waits in that register while the next word is
// accepted; the load waits longer while that register still holds a result not
// yet taken. A run word keeps the input closed until done. A run over zero
// cells goes straight back to idle. Otherwise the prep pass does, per cell, one
// chance memory read and accumulate per class (at least one) and one result
// write, and each greedy step does a list read, chance read and compare per
// active class and remaining list entry, a lone list-read step per inactive
// class slot, and the search start, the write-back and the list swap, all
// bounded by the single port of the chance memory. No clearing pass after
// reset; result and chance entries are meaningful once written.
module area_limited_greedy_class_assign (
  input  logic      clk,
  input  logic      rst_n,
  acg_in_if.sink    in_chan,
  acg_out_if.source out_chan
);
  import acg_pkg::*;

  acg_cmd_t  cmd;
  acg_stat_t stat;

  // sequencer
  acg_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_chan.valid),
    .in_op         (in_chan.operation),
    .in_cell_count (in_chan.cell_count),
    .in_ready      (in_chan.ready),
    .stat          (stat),
    .cmd           (cmd)
  );

  // memories, class state and search
  acg_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_class_index    (in_chan.class_index),
    .in_cell_index     (in_chan.cell_index),
    .in_class_id       (in_chan.class_id),
    .in_area_limit     (in_chan.area_limit),
    .in_chance         (in_chan.chance),
    .in_chance_missing (in_chan.chance_missing),
    .in_cell_count     (in_chan.cell_count),
    .in_class_count    (in_chan.class_count),
    .out_valid         (out_chan.valid),
    .out_ready         (out_chan.ready),
    .out_cell          (out_chan.result_cell),
    .out_class_id      (out_chan.result_class_id),
    .out_missing       (out_chan.result_missing)
  );

endmodule
